// ----- rtl/core/qau_pkg.sv -----
// shared types, widths and helpers of the quaternion arithmetic unit
`default_nettype none

package qau_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int PW        = 2 * DW;
  localparam int SUMW      = PW + 2;
  localparam int SW        = 34;
  localparam int SQ_STEPS  = 17;
  localparam int MW        = 17;
  localparam int QW        = FRAC_BITS + 1;
  localparam int NW        = DW + FRAC_BITS + 2;

  localparam logic [1:0] MODE_PROD = 2'd0;
  localparam logic [1:0] MODE_CONJ = 2'd1;
  localparam logic [1:0] MODE_MAG  = 2'd2;
  localparam logic [1:0] MODE_NORM = 2'd3;

  typedef logic [3:0][DW-1:0] quat_t;
  typedef logic [3:0][QW-1:0] quo_t;

  typedef struct packed {
    logic [1:0] mode;
    quat_t      a;
    quat_t      res;
    logic       sat;
  } side_t;

  // clip to 16 bits signed, flag in the top bit
  function automatic logic [DW:0] sat16(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = SUMW'((2 ** (DW - 1)) - 1);
    lo = -hi - SUMW'(1);
    if (v > hi) begin
      sat16 = {1'b1, hi[DW-1:0]};
    end else if (v < lo) begin
      sat16 = {1'b1, lo[DW-1:0]};
    end else begin
      sat16 = {1'b0, v[DW-1:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qau_front.sv -----
// multiplier stage, product sums, conjugate and sum of squares
`default_nettype none

module qau_front import qau_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [1:0]    mode_i,
  input  wire quat_t         a_i,
  input  wire quat_t         b_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [SW-1:0]      sumsq_o
);

  logic signed [PW-1:0] prod_q [4][4];
  logic signed [PW-1:0] sq_q [4];
  logic [1:0]           mode_q;
  quat_t                a_q;
  logic                 v1_q, v2_q;
  side_t                side_d, side_q;
  logic [SW-1:0]        sumsq_d, sumsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[i][j] <= $signed(a_i[i]) * $signed(b_i[j]);
        end
        sq_q[i] <= $signed(a_i[i]) * $signed(a_i[i]);
      end
      mode_q <= mode_i;
      a_q    <= a_i;
      side_q  <= side_d;
      sumsq_q <= sumsq_d;
    end
  end

  logic signed [SUMW-1:0] c [4];
  logic signed [SUMW-1:0] rnd [4];
  logic [DW:0]            ps [4];
  logic [DW:0]            cs [4];

  always_comb begin
    c[0] = SUMW'(prod_q[0][0]) - SUMW'(prod_q[1][1]) - SUMW'(prod_q[2][2])
         - SUMW'(prod_q[3][3]);
    c[1] = SUMW'(prod_q[0][1]) + SUMW'(prod_q[1][0]) + SUMW'(prod_q[2][3])
         - SUMW'(prod_q[3][2]);
    c[2] = SUMW'(prod_q[0][2]) - SUMW'(prod_q[1][3]) + SUMW'(prod_q[2][0])
         + SUMW'(prod_q[3][1]);
    c[3] = SUMW'(prod_q[0][3]) + SUMW'(prod_q[1][2]) - SUMW'(prod_q[2][1])
         + SUMW'(prod_q[3][0]);
    for (int i = 0; i < 4; i++) begin
      // round half up, then floor shift
      rnd[i] = (c[i] + (SUMW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      ps[i]  = sat16(rnd[i]);
      cs[i]  = sat16(-SUMW'($signed(a_q[i])));
    end
    sumsq_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
    side_d.mode = mode_q;
    side_d.a    = a_q;
    side_d.res  = '0;
    side_d.sat  = 1'b0;
    case (mode_q)
      MODE_PROD: begin
        for (int i = 0; i < 4; i++) side_d.res[i] = ps[i][DW-1:0];
        side_d.sat = ps[0][DW] | ps[1][DW] | ps[2][DW] | ps[3][DW];
      end
      MODE_CONJ: begin
        side_d.res[0] = a_q[0];
        for (int i = 1; i < 4; i++) side_d.res[i] = cs[i][DW-1:0];
        side_d.sat = cs[1][DW] | cs[2][DW] | cs[3][DW];
      end
      default: begin
        side_d.res = '0;
      end
    endcase
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;
  assign sumsq_o = sumsq_q;

endmodule

`default_nettype wire

// ----- rtl/core/qau_sqrt.sv -----
// pipelined integer square root, one result bit per stage
`default_nettype none

module qau_sqrt import qau_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire side_t         side_i,
  input  wire logic [SW-1:0] s_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [SW-1:0]      n_o,
  output logic [SW-1:0]      r_o
);

  logic          v_s [SQ_STEPS+1];
  side_t         side_s [SQ_STEPS+1];
  logic [SW-1:0] n_s [SQ_STEPS+1];
  logic [SW-1:0] r_s [SQ_STEPS+1];

  assign v_s[0]    = valid_i;
  assign side_s[0] = side_i;
  assign n_s[0]    = s_i;
  assign r_s[0]    = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SW-1:0] Bit = SW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SW-1:0] t;
    logic [SW-1:0] n_d, r_d;

    always_comb begin
      t = r_s[k] + Bit;
      if (n_s[k] >= t) begin
        n_d = n_s[k] - t;
        r_d = (r_s[k] >> 1) + Bit;
      end else begin
        n_d = n_s[k];
        r_d = r_s[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[k+1] <= side_s[k];
        n_s[k+1]    <= n_d;
        r_s[k+1]    <= r_d;
      end
    end
  end

  assign valid_o = v_s[SQ_STEPS];
  assign side_o  = side_s[SQ_STEPS];
  assign n_o     = n_s[SQ_STEPS];
  assign r_o     = r_s[SQ_STEPS];

endmodule

`default_nettype wire

// ----- rtl/core/qau_div.sv -----
// root rounding and four restoring dividers for normalize
`default_nettype none

module qau_div import qau_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire side_t         side_i,
  input  wire logic [SW-1:0] n_i,
  input  wire logic [SW-1:0] r_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [MW-1:0]      m_o,
  output quo_t               q_o
);

  logic          v_s [QW+1];
  side_t         side_s [QW+1];
  logic [MW-1:0] m_s [QW+1];
  logic [NW-1:0] rem_s [QW+1][4];
  quo_t          q_s [QW+1];

  // round to nearest: remainder above root means step up
  logic [MW-1:0] m_d;
  logic [NW-1:0] num_d [4];
  logic [DW-1:0] absa;

  always_comb begin
    m_d = MW'(r_i) + MW'(n_i > r_i);
    for (int i = 0; i < 4; i++) begin
      absa = side_i.a[i][DW-1] ? (~side_i.a[i] + DW'(1)) : side_i.a[i];
      num_d[i] = (NW'(absa) << (FRAC_BITS + 1)) + NW'(m_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_s[0] <= side_i;
      m_s[0]    <= m_d;
      q_s[0]    <= '0;
      for (int i = 0; i < 4; i++) rem_s[0][i] <= num_d[i];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int Sh = QW - 1 - k;
    logic [NW-1:0] dsh;
    logic [NW-1:0] rem_d [4];
    quo_t          q_d;

    always_comb begin
      dsh = NW'({m_s[k], 1'b0}) << Sh;
      q_d = q_s[k];
      for (int i = 0; i < 4; i++) begin
        if (rem_s[k][i] >= dsh) begin
          rem_d[i]   = rem_s[k][i] - dsh;
          q_d[i][Sh] = 1'b1;
        end else begin
          rem_d[i] = rem_s[k][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[k+1] <= side_s[k];
        m_s[k+1]    <= m_s[k];
        q_s[k+1]    <= q_d;
        for (int i = 0; i < 4; i++) rem_s[k+1][i] <= rem_d[i];
      end
    end
  end

  assign valid_o = v_s[QW];
  assign side_o  = side_s[QW];
  assign m_o     = m_s[QW];
  assign q_o     = q_s[QW];

endmodule

`default_nettype wire

// ----- rtl/core/quaternion_arith_unit.sv -----
// quaternion arithmetic unit: product, conjugate, magnitude, normalize
// usage:
//   input transfer on the slave side: tuser carries the mode (0 product,
//   1 conjugate, 2 magnitude, 3 normalize), tdata carries A then B in
//   signed Q2.14. one result transfer on the master side per input:
//   components, magnitude and the saturated and zero_length flags.
//   the unit is a fixed pipeline of 36 register stages: two for the
//   multipliers and sums, 17 for the square root (one root bit per stage),
//   one for root rounding, 15 for the normalize dividers (one quotient bit
//   per stage) and the output register. one item is taken every cycle
//   while the receiver does not stall.
//   every mode goes through the same stages, so results leave in order.
//   when the receiver stalls with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is dropped or repeated.
//   reset empties the pipeline; there is no other state.
`default_nettype none

module quaternion_arith_unit import qau_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  wire logic [127:0] s_axis_tdata,
  // mode
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // res_w, res_x, res_y, res_z, magnitude
  output logic [79:0]       m_axis_tdata,
  // saturated, zero_length
  output logic [1:0]        m_axis_tuser
);

  logic en;
  logic out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  quat_t a_in, b_in;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_in[i] = s_axis_tdata[i*DW +: DW];
      b_in[i] = s_axis_tdata[(i+4)*DW +: DW];
    end
  end

  logic          f_v;
  side_t         f_side;
  logic [SW-1:0] f_sumsq;

  qau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .mode_i  (s_axis_tuser),
    .a_i     (a_in),
    .b_i     (b_in),
    .valid_o (f_v),
    .side_o  (f_side),
    .sumsq_o (f_sumsq)
  );

  logic          s_v;
  side_t         s_side;
  logic [SW-1:0] s_n, s_r;

  qau_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .side_i  (f_side),
    .s_i     (f_sumsq),
    .valid_o (s_v),
    .side_o  (s_side),
    .n_o     (s_n),
    .r_o     (s_r)
  );

  logic          d_v;
  side_t         d_side;
  logic [MW-1:0] d_m;
  quo_t          d_q;

  qau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_v),
    .side_i  (s_side),
    .n_i     (s_n),
    .r_i     (s_r),
    .valid_o (d_v),
    .side_o  (d_side),
    .m_o     (d_m),
    .q_o     (d_q)
  );

  // only 65536 reaches the top root bit
  logic          mag_sat;
  logic [DW-1:0] mag16;
  logic [DW-1:0] qv;
  quat_t         res_d, res_q;
  logic [DW-1:0] mag_d, mag_q;
  logic          sat_d, sat_q, zero_d, zero_q;

  always_comb begin
    mag_sat = d_m[MW-1];
    mag16   = mag_sat ? {DW{1'b1}} : d_m[DW-1:0];
    res_d   = d_side.res;
    mag_d   = '0;
    sat_d   = d_side.sat;
    zero_d  = 1'b0;
    qv      = '0;
    case (d_side.mode)
      MODE_MAG: begin
        res_d = '0;
        mag_d = mag16;
        sat_d = mag_sat;
      end
      MODE_NORM: begin
        if (d_m == '0) begin
          res_d  = '0;
          sat_d  = 1'b0;
          zero_d = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            qv       = DW'(d_q[i]);
            res_d[i] = d_side.a[i][DW-1] ? (~qv + DW'(1)) : qv;
          end
          mag_d = mag16;
          sat_d = mag_sat;
        end
      end
      default: begin
        res_d = d_side.res;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      mag_q  <= mag_d;
      sat_q  <= sat_d;
      zero_q <= zero_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {mag_q, res_q};
  assign m_axis_tuser  = {zero_q, sat_q};

endmodule

`default_nettype wire

// ----- rtl/core/qau_checker.sv -----
// port-level checks of the quaternion arithmetic unit and their binding
`default_nettype none

module qau_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [79:0]  m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  // empty pipeline during reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("zero length result not clean");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind quaternion_arith_unit qau_checker u_qau_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench of the quaternion arithmetic unit
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qau_pkg::*;

  typedef struct {
    logic [15:0] w, x, y, z, mag;
    logic        sat, zero;
  } quat_result_t;

  class quat_scoreboard;
    quat_result_t pending[$];
    int errors;

    function automatic logic signed [15:0] clip(input longint v, ref logic sat);
      if (v > 32767) begin
        sat = 1'b1;
        return 16'sd32767;
      end
      if (v < -32768) begin
        sat = 1'b1;
        return -16'sd32768;
      end
      return v[15:0];
    endfunction

    function automatic longint round_q(input longint v);
      return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint isqrt_round(input longint unsigned s);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 65537;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= s) lo = mid;
        else hi = mid - 1;
      end
      if (s - lo * lo > lo) lo++;
      return lo;
    endfunction

    function void note_input(input logic [1:0] mode, input logic [127:0] data);
      longint a[4], b[4], p[4];
      longint unsigned s, m, mg, q;
      quat_result_t r;
      logic sat;
      for (int i = 0; i < 4; i++) begin
        a[i] = longint'($signed(data[16*i +: 16]));
        b[i] = longint'($signed(data[64 + 16*i +: 16]));
      end
      sat = 1'b0;
      r = '{default: '0};
      case (mode)
        MODE_PROD: begin
          p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
          p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
          p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
          p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
          r.w = clip(round_q(p[0]), sat);
          r.x = clip(round_q(p[1]), sat);
          r.y = clip(round_q(p[2]), sat);
          r.z = clip(round_q(p[3]), sat);
        end
        MODE_CONJ: begin
          r.w = a[0][15:0];
          r.x = clip(-a[1], sat);
          r.y = clip(-a[2], sat);
          r.z = clip(-a[3], sat);
        end
        default: begin
          s = 0;
          for (int i = 0; i < 4; i++) s += longint'(a[i] * a[i]);
          m = isqrt_round(s);
          if (mode == MODE_NORM && m == 0) begin
            r.zero = 1'b1;
          end else begin
            if (m > 65535) begin
              r.mag = 16'hffff;
              sat = 1'b1;
            end else begin
              r.mag = m[15:0];
            end
            if (mode == MODE_NORM) begin
              for (int i = 0; i < 4; i++) begin
                mg = (a[i] < 0) ? -a[i] : a[i];
                q = ((mg << (FRAC_BITS + 1)) + m) / (2 * m);
                p[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
              end
              r.w = clip(p[0], sat);
              r.x = clip(p[1], sat);
              r.y = clip(p[2], sat);
              r.z = clip(p[3], sat);
            end
          end
        end
      endcase
      r.sat = sat;
      pending.push_back(r);
    endfunction

    function void check_result(input logic [79:0] data, input logic [1:0] user);
      quat_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %b", data, user);
        return;
      end
      e = pending.pop_front();
      if (data !== {e.mag, e.z, e.y, e.x, e.w} || user !== {e.zero, e.sat}) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h %b%b got %h %b",
                   {e.mag, e.z, e.y, e.x, e.w}, e.zero, e.sat, data, user);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = MODE_PROD;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  quat_scoreboard quat_sb = new();
  bit calm_phase;
  bit sink_hold;
  int idle_cycles;
  int sent_items;

  always #5 clk_i = ~clk_i;

  quaternion_arith_unit dut (.*);

  // input transfers are noted, output transfers checked, at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      quat_sb.note_input(s_axis_tuser, s_axis_tdata);
      sent_items++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      quat_sb.check_result(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= !sink_hold && (calm_phase || $urandom_range(99) >= 27);

  // starts and ends at a falling edge; valid stays high for the next item
  task automatic send_item(input logic [1:0] mode, input logic [127:0] data);
    while (!calm_phase && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000 ^ {16{$urandom_range(1) == 1}};
      3: return 16'($urandom_range(31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [127:0] pick_data();
    logic [127:0] d;
    for (int i = 0; i < 8; i++) d[16*i +: 16] = pick_comp();
    if ($urandom_range(9) == 0) d[63:0] = '0;
    return d;
  endfunction

  initial begin
    logic [1:0] modes[4];
    rst_ni = 1'b0;
    modes = '{MODE_PROD, MODE_CONJ, MODE_MAG, MODE_NORM};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    calm_phase = 1'b1;
    foreach (modes[k]) begin
      send_item(modes[k], '0);
      send_item(modes[k], {8{16'h8000}});
      send_item(modes[k], {8{16'h7fff}});
      send_item(modes[k], {{4{16'h4000}}, 16'h0, 16'h0, 16'h0, 16'h0001});
      send_item(modes[k], {16'hc000, 16'h4000, 16'hffff, 16'h0001,
                           16'h0001, 16'hffff, 16'h2000, 16'he000});
    end
    send_item(MODE_NORM, {64'h0, 16'h0, 16'h0, 16'h0, 16'h0001});
    // hold the receiver off so the pipeline fills and input stalls
    sink_hold = 1'b1;
    fork
      begin
        repeat (80) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      for (int n = 0; n < 60; n++) send_item(2'($urandom), pick_data());
    join
    for (int n = 0; n < 390; n++) begin
      calm_phase = (n >= 150 && n < 230);
      send_item(2'($urandom), pick_data());
    end
    s_axis_tvalid <= 1'b0;
    calm_phase = 1'b0;
    while (quat_sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (quat_sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire
